// ===== rtl/tsi_pkg.sv =====
package tsi_pkg;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One queue entry: at most one space, then an optional main byte.
    // An entry with no spaces and no main byte is a bare line-end marker.
    typedef struct packed {
        logic [7:0] main_char;
        logic [1:0] num_spaces;
        logic       has_main;
        logic       line_end;
    } tsi_entry_t;

    function automatic logic is_operator(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_SLASH) ||
               (c == CH_STAR) || (c == CH_COLON) || (c == CH_LBRACE) || (c == CH_RBRACE);
    endfunction

endpackage

// ===== rtl/tsi_front.sv =====
module tsi_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [7:0]         in_char,
    input  logic               in_last,
    output logic               in_ready,
    output logic               push,
    output tsi_pkg::tsi_entry_t push_entry,
    input  logic               push_ready
);
    import tsi_pkg::*;

    logic inside_reg, inside_next;
    logic single_reg, single_next;
    logic bslash_reg, bslash_next;
    logic has_out_reg, has_out_next;
    logic last_sp_reg, last_sp_next;
    logic pend_reg, pend_next;

    logic       accept;
    logic       is_quote, quote_single, quote_live, quote_struct, dropped, op;
    logic       emit_pend, emit_lead, emit_main;
    logic [7:0] ch, main_c;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    always_comb begin
        ch           = (in_char == CH_COMMA) ? CH_SPACE : in_char;
        is_quote     = (in_char == CH_DQUOTE) || (in_char == CH_SQUOTE);
        quote_single = (in_char == CH_SQUOTE);
        quote_live   = is_quote && !bslash_reg;
        quote_struct = quote_live && (!inside_reg || (quote_single == single_reg));
        dropped      = quote_live && !quote_struct;
        op           = !quote_live && !inside_reg && is_operator(in_char);
        emit_pend    = pend_reg && (in_char != CH_SPACE);
        // held space already leaves the line ending in a space
        emit_lead    = (quote_struct || op) && !emit_pend && has_out_reg && !last_sp_reg;
        emit_main    = !dropped;
        main_c       = (quote_struct || op) ? in_char : ch;

        push_entry.main_char  = emit_main ? main_c : 8'd0;
        push_entry.num_spaces = {1'b0, emit_pend} + {1'b0, emit_lead};
        push_entry.has_main   = emit_main;
        push_entry.line_end   = in_last;
        push = accept && (emit_main || emit_pend || in_last);

        inside_next  = inside_reg;
        single_next  = single_reg;
        bslash_next  = bslash_reg;
        has_out_next = has_out_reg;
        last_sp_next = last_sp_reg;
        pend_next    = pend_reg;
        if (accept) begin
            if (in_last) begin
                inside_next  = 1'b0;
                single_next  = 1'b0;
                bslash_next  = 1'b0;
                has_out_next = 1'b0;
                last_sp_next = 1'b0;
                pend_next    = 1'b0;
            end else begin
                if (quote_struct) begin
                    inside_next = !inside_reg;
                    single_next = inside_reg ? 1'b0 : quote_single;
                end
                bslash_next  = (in_char == CH_BSLASH);
                has_out_next = has_out_reg || emit_main || emit_pend;
                if (emit_main) begin
                    last_sp_next = (main_c == CH_SPACE);
                end else if (emit_pend) begin
                    last_sp_next = 1'b1;
                end
                pend_next = quote_struct || op;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg  <= 1'b0;
            single_reg  <= 1'b0;
            bslash_reg  <= 1'b0;
            has_out_reg <= 1'b0;
            last_sp_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            inside_reg  <= inside_next;
            single_reg  <= single_next;
            bslash_reg  <= bslash_next;
            has_out_reg <= has_out_next;
            last_sp_reg <= last_sp_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

// ===== rtl/tsi_queue.sv =====
module tsi_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  tsi_pkg::tsi_entry_t wr_entry,
    output logic               wr_ready,
    output logic               rd_valid,
    output tsi_pkg::tsi_entry_t rd_entry,
    input  logic               rd_en
);
    import tsi_pkg::*;

    tsi_entry_t      mem [QDEPTH];
    logic [QAW-1:0]  wptr_reg, wptr_next;
    logic [QAW-1:0]  rptr_reg, rptr_next;
    logic [QAW:0]    cnt_reg, cnt_next;
    logic            do_wr, do_rd;

    assign wr_ready = (cnt_reg != QDEPTH[QAW:0]);
    assign rd_valid = (cnt_reg != '0);
    assign rd_entry = mem[rptr_reg];
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        wptr_next = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + {{QAW{1'b0}}, do_wr} - {{QAW{1'b0}}, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/tsi_back.sv =====
module tsi_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  tsi_pkg::tsi_entry_t q_entry,
    output logic               q_pop,
    output logic               out_valid,
    output logic [7:0]         out_char,
    output logic               out_has,
    output logic               out_last,
    input  logic               out_ready
);
    import tsi_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       vld_reg, vld_next;
    logic [7:0] char_reg, char_next;
    logic       has_reg, has_next;
    logic       last_reg, last_next;

    logic [1:0] total;
    logic       emit, final_beat, in_spaces;

    always_comb begin
        total      = q_entry.num_spaces + {1'b0, q_entry.has_main};
        if (total == 2'd0) begin
            total = 2'd1;   // bare end marker
        end
        emit       = q_valid && (!vld_reg || out_ready);
        final_beat = (idx_reg == total - 2'd1);
        in_spaces  = (idx_reg < q_entry.num_spaces);
        q_pop      = emit && final_beat;

        idx_next  = idx_reg;
        vld_next  = vld_reg;
        char_next = char_reg;
        has_next  = has_reg;
        last_next = last_reg;
        if (emit) begin
            idx_next  = final_beat ? 2'd0 : idx_reg + 2'd1;
            vld_next  = 1'b1;
            char_next = in_spaces ? CH_SPACE : q_entry.main_char;
            has_next  = in_spaces || q_entry.has_main;
            last_next = final_beat && q_entry.line_end;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
            vld_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        has_reg  <= has_next;
        last_reg <= last_next;
    end

    assign out_valid = vld_reg;
    assign out_char  = char_reg;
    assign out_has   = has_reg;
    assign out_last  = last_reg;

endmodule

// ===== rtl/token_space_inserter_top.sv =====
// channel | dir | tdata        | tuser    | tlast
// s_      | in  | [7:0] in_char | -        | line_end
// m_      | out | [7:0] out_char| has_char | line_done
//
// Input takes one beat per cycle while the 4-entry queue has room.
// Output gives one beat per cycle while m_tready is high; an input byte yields 0 to 2 output
// beats, so throughput is set by the output register draining the queue.
// With queue and output idle, an accepted input beat is written into the queue and
// then loaded into the output register, which drives its first output beat.
// aresetn is synchronous, active low; clears line state, queue and output.
module token_space_inserter_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tuser,   // [0] has_char
    output logic       m_tlast
);
    import tsi_pkg::*;

    tsi_entry_t push_entry, head_entry;
    logic       push, push_ready, head_valid, pop;

    tsi_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    tsi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (push),
        .wr_entry (push_entry),
        .wr_ready (push_ready),
        .rd_valid (head_valid),
        .rd_entry (head_entry),
        .rd_en    (pop)
    );

    tsi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (head_valid),
        .q_entry   (head_entry),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_char  (m_tdata),
        .out_has   (m_tuser),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

endmodule

// ===== test/token_space_inserter_checker.sv =====
module token_space_inserter_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_char
    input  logic       m_tuser,   // [0] has_char
    input  logic       m_tlast,
    output int         errors,
    output int         outstanding
);
    import tsi_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       done;
    } out_beat_t;

    out_beat_t  due_q[$];
    out_beat_t  step_beats[3];
    int         step_n;
    int         fail_total;

    // per-line respacing state, cleared at every line end
    logic in_str;
    logic str_single;
    logic after_bslash;
    logic line_started;
    logic ended_in_space;
    logic space_held;

    function automatic logic is_spaced_op(input logic [7:0] c);
        case (c)
            CH_EQ, CH_PLUS, CH_MINUS, CH_SLASH,
            CH_STAR, CH_COLON, CH_LBRACE, CH_RBRACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function void clear_line();
        in_str         = 1'b0;
        str_single     = 1'b0;
        after_bslash   = 1'b0;
        line_started   = 1'b0;
        ended_in_space = 1'b0;
        space_held     = 1'b0;
    endfunction

    function void put_char(input logic [7:0] c);
        step_beats[step_n] = {c, 1'b1, 1'b0};
        step_n         = step_n + 1;
        line_started   = 1'b1;
        ended_in_space = (c == CH_SPACE);
    endfunction

    function void put_lead_space();
        if (line_started && !ended_in_space)
            put_char(CH_SPACE);
    endfunction

    task respace(input logic [7:0] raw, input logic eol);
        logic [7:0] ch;
        logic       quote;
        logic       single;
        int         i;
        ch     = (raw == CH_COMMA) ? CH_SPACE : raw;
        quote  = (raw == CH_DQUOTE) || (raw == CH_SQUOTE);
        step_n = 0;

        // held space: emitted unless the next raw byte is itself a space
        if (space_held) begin
            space_held = 1'b0;
            if (raw != CH_SPACE)
                put_char(CH_SPACE);
        end

        if (quote && !after_bslash) begin
            single = (raw == CH_SQUOTE);
            // quote of the other kind inside a string is dropped
            if (!in_str || single == str_single) begin
                put_lead_space();
                put_char(raw);
                if (in_str) begin
                    in_str     = 1'b0;
                    str_single = 1'b0;
                end else begin
                    in_str     = 1'b1;
                    str_single = single;
                end
                space_held = 1'b1;
            end
        end else if (in_str) begin
            put_char(ch);
        end else if (is_spaced_op(raw)) begin
            put_lead_space();
            put_char(raw);
            space_held = 1'b1;
        end else begin
            put_char(ch);
        end

        after_bslash = (raw == CH_BSLASH);

        if (eol) begin
            // line ending on a dropped quote with no held space closes with a bare marker
            if (step_n == 0) begin
                step_beats[0] = {8'h00, 1'b0, 1'b0};
                step_n = 1;
            end
            step_beats[step_n-1].done = 1'b1;
            clear_line();
        end

        for (i = 0; i < step_n; i++)
            due_q.insert(due_q.size(), step_beats[i]);
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            clear_line();
            due_q.delete();
            fail_total = 0;
        end else begin
            if (s_tvalid && s_tready)
                respace(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (due_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected beat: expected none, actual char=%h has=%b done=%b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = due_q.pop_front();
                    if (m_tdata !== want.ch) begin
                        fail_total++;
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $time, want.ch, m_tdata);
                    end
                    if (m_tuser !== want.has_char) begin
                        fail_total++;
                        $display("%0t: has_char mismatch: expected %b, actual %b",
                                 $time, want.has_char, m_tuser);
                    end
                    if (m_tlast !== want.done) begin
                        fail_total++;
                        $display("%0t: line_done mismatch: expected %b, actual %b",
                                 $time, want.done, m_tlast);
                    end
                end
            end
        end
        errors      <= fail_total;
        outstanding <= due_q.size();
    end

endmodule

// ===== test/token_space_inserter_top_test.sv =====
module token_space_inserter_top_test;
    import tsi_pkg::*;

    localparam int LIMIT     = 200000;
    localparam int N_ITEMS   = 250;
    localparam int HOLD_LEN  = 300;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    int fail_total;
    int outstanding;
    int sent = 0;
    bit gaps_on = 1'b1;
    bit long_hold = 1'b0;
    bit hold_done = 1'b0;

    logic [7:0] op_set [8] = '{CH_EQ, CH_PLUS, CH_MINUS, CH_SLASH,
                               CH_STAR, CH_COLON, CH_LBRACE, CH_RBRACE};

    token_space_inserter_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    token_space_inserter_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (fail_total),
        .outstanding (outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                long_hold = 1'b0;
                m_tready = 1'b1;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 11))
            0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
            3:       return CH_SPACE;
            4:       return CH_COMMA;
            5, 6:    return op_set[$urandom_range(0, 7)];
            7:       return $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            8:       return CH_BSLASH;
            9:       return 8'h30 + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eol);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom);
            s_tlast  = 1'($urandom);
            repeat ($urandom_range(0, 12)) @(negedge aclk);
        end
    endtask

    task automatic send_line(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_byte(txt[i], i == txt.len() - 1);
    endtask

    task automatic send_random_line();
        int n;
        int i;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (i = 0; i < n; i++)
            send_byte(pick_char(), i == n - 1);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_line("a=b");
        send_line("x,+");        // token then comma: one space, no lead space before the operator
        send_line("\"+\"");      // operator inside a string passes as is
        send_line("'\"'");       // other quote kind inside a string is dropped
        send_line("\\'");        // escaped quote is plain text
        send_line("\"'");        // line ends on a dropped quote: the held space closes the line
        send_line("{ }");        // held space dropped before a raw space
        send_line(":*-/");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        while (sent < N_ITEMS) begin
            if (sent >= 100 && !hold_done) begin
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            if (sent >= N_ITEMS - 50)
                gaps_on = 1'b0;
            send_random_line();
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_total == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
